FILE: rtl/ogd_pkg.sv
// ----------------------------------------------------------------------------
// ogd_pkg: shared constants for the octile grid distance block
// Field widths of the ports and the step costs in tenths of a step.
// ----------------------------------------------------------------------------
package ogd_pkg;

  // Port field widths.
  localparam int unsigned INDEX_FIELD_W = 24;
  localparam int unsigned DIST_W        = 28;
  localparam int unsigned CFG_W         = 13;

  // Largest distance the result field can carry.
  localparam logic [DIST_W-1:0] DIST_MAX = 28'hFFF_FFFF;

  // Step costs in tenths: a diagonal step is 1.4, a straight step is 1.0.
  localparam int unsigned DIAG_TENTHS     = 14;
  localparam int unsigned STRAIGHT_TENTHS = 10;

endpackage

FILE: rtl/ogd_front.sv
// ----------------------------------------------------------------------------
// ogd_front: input stage and row width register
// Captures each item, trims the indices to the working width and hands the
// item to the queue. Also holds the clamped row width used by the divider.
// ----------------------------------------------------------------------------
module ogd_front #(
  parameter int unsigned INDEX_BITS = 24,
  parameter int unsigned WIDTH_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ogd_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ogd_pkg::INDEX_FIELD_W-1:0]  in_first_index,
  input  logic [ogd_pkg::INDEX_FIELD_W-1:0]  in_second_index,
  output logic                               push_valid,
  input  logic                               push_full,
  output logic [2*INDEX_BITS-1:0]            push_data,
  output logic [WIDTH_BITS:0]                eff_width
);

  // Width wide enough to compare the written value with the row width limit.
  localparam int unsigned EW = (WIDTH_BITS + 1 > ogd_pkg::CFG_W) ?
                               WIDTH_BITS + 1 : ogd_pkg::CFG_W;

  logic                  front_valid_r, front_valid_nxt;
  logic [INDEX_BITS-1:0] first_r, second_r;
  logic [WIDTH_BITS:0]   width_r, width_nxt;
  logic [EW-1:0]         cfg_ext;
  logic [EW-1:0]         width_lim;
  logic                  load;
  logic                  push;

  // Handshake: the stage holds one item and frees itself when the queue takes it.
  assign push     = front_valid_r && !push_full;
  assign in_stall = front_valid_r && push_full;
  assign load     = in_valid && !in_stall;

  always_comb begin
    front_valid_nxt = front_valid_r;
    if (load) begin
      front_valid_nxt = 1'b1;
    end else if (push) begin
      front_valid_nxt = 1'b0;
    end
  end

  // Row width clamp: zero counts as one, anything above the limit as the limit.
  assign cfg_ext   = EW'(cfg_wdata);
  assign width_lim = EW'(1) << WIDTH_BITS;

  always_comb begin
    width_nxt = width_r;
    if (cfg_we) begin
      if (cfg_ext == '0) begin
        width_nxt = (WIDTH_BITS + 1)'(1);
      end else if (cfg_ext > width_lim) begin
        width_nxt = width_lim[WIDTH_BITS:0];
      end else begin
        width_nxt = cfg_ext[WIDTH_BITS:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_valid_r <= 1'b0;
      width_r       <= (WIDTH_BITS + 1)'(1);
    end else begin
      front_valid_r <= front_valid_nxt;
      width_r       <= width_nxt;
    end
  end

  // Indices are reduced to the working index width on capture.
  always_ff @(posedge clk) begin
    if (load) begin
      first_r  <= INDEX_BITS'(in_first_index);
      second_r <= INDEX_BITS'(in_second_index);
    end
  end

  assign push_valid = push;
  assign push_data  = {first_r, second_r};
  assign eff_width  = width_r;

`ifndef ASSERT_OFF
  // The divider must never see a zero or oversized row width.
  a_width_range: assert property (@(posedge clk) disable iff (!rst_n)
    (width_r != '0) && ({1'b0, width_r} <= ((WIDTH_BITS + 2)'(1) << WIDTH_BITS)))
    else $error("row width out of range");

  // The input is held back only while an item waits for a full queue.
  a_stall_holds_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (front_valid_r && push_full))
    else $error("input stalled without a waiting item");
`endif

endmodule

FILE: rtl/ogd_queue.sv
// ----------------------------------------------------------------------------
// ogd_queue: short item queue
// Small first-in first-out buffer between the front and back stages, so that
// either side can stall without stopping the other at once.
// ----------------------------------------------------------------------------
module ogd_queue #(
  parameter int unsigned DATA_W = 48,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  output logic              full,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              not_empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  // Pointer wrap and fill count.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage write.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  // The fill count never passes the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count above depth");

  // Nothing is taken from an empty queue.
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("pop from empty queue");
`endif

endmodule

FILE: rtl/ogd_back.sv
// ----------------------------------------------------------------------------
// ogd_back: divider pipeline and distance stage
// Splits both indices into row and column with a pipelined restoring divider,
// one quotient bit per stage, then forms the octile distance in tenths.
// ----------------------------------------------------------------------------
module ogd_back #(
  parameter int unsigned INDEX_BITS = 24,
  parameter int unsigned WIDTH_BITS = 12
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  logic [2*INDEX_BITS-1:0]     q_data,
  output logic                        q_pop,
  input  logic [WIDTH_BITS:0]         eff_width,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [ogd_pkg::DIST_W-1:0]  out_distance_tenths
);

  localparam int unsigned IB = INDEX_BITS;
  localparam int unsigned WB = WIDTH_BITS;
  localparam int unsigned MW = (IB > WB) ? IB : WB;
  localparam int unsigned DW = MW + 4;
  localparam int unsigned CW = (DW > ogd_pkg::DIST_W) ? DW : ogd_pkg::DIST_W;
  localparam logic [DW-1:0] STRAIGHT_K = DW'(ogd_pkg::STRAIGHT_TENTHS);
  localparam logic [DW-1:0] EXTRA_K    = DW'(ogd_pkg::DIAG_TENTHS - ogd_pkg::STRAIGHT_TENTHS);

  logic          adv;
  logic [IB-1:0] q_first, q_second;

  // Divider stage registers: shifting dividend/quotient and partial remainder.
  logic          v_r   [IB];
  logic [IB-1:0] dqa_r [IB];
  logic [IB-1:0] dqb_r [IB];
  logic [WB-1:0] ra_r  [IB];
  logic [WB-1:0] rb_r  [IB];

  // Difference, ordering and output stages.
  logic          x_v_r;
  logic [WB-1:0] dx_r;
  logic [IB-1:0] dy_r;
  logic          y_v_r;
  logic [MW-1:0] lo_r, hi_r;
  logic          out_valid_r;
  logic [ogd_pkg::DIST_W-1:0] out_dist_r;

  logic [MW-1:0] dx_ext, dy_ext;
  logic [DW-1:0] dist_raw;
  logic [CW-1:0] dist_cmp;
  logic [ogd_pkg::DIST_W-1:0] dist_sat;

  // The whole pipeline moves together unless a finished result is held.
  assign adv      = !out_valid_r || !out_stall;
  assign q_pop    = adv && q_valid;
  assign q_first  = q_data[2*IB-1:IB];
  assign q_second = q_data[IB-1:0];

  // One restoring division step per stage for both indices.
  for (genvar k = 0; k < IB; k++) begin : g_div
    logic          vi;
    logic [IB-1:0] dqa_i, dqb_i;
    logic [WB-1:0] ra_i, rb_i;
    logic [WB:0]   ta, tb;
    logic          ga, gb;

    if (k == 0) begin : g_head
      assign vi    = q_pop;
      assign dqa_i = q_first;
      assign dqb_i = q_second;
      assign ra_i  = '0;
      assign rb_i  = '0;
    end else begin : g_body
      assign vi    = v_r[k-1];
      assign dqa_i = dqa_r[k-1];
      assign dqb_i = dqb_r[k-1];
      assign ra_i  = ra_r[k-1];
      assign rb_i  = rb_r[k-1];
    end

    assign ta = {ra_i, dqa_i[IB-1]};
    assign tb = {rb_i, dqb_i[IB-1]};
    assign ga = (ta >= eff_width);
    assign gb = (tb >= eff_width);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dqa_r[k] <= {dqa_i[IB-2:0], ga};
        dqb_r[k] <= {dqb_i[IB-2:0], gb};
        ra_r[k]  <= ga ? WB'(ta - eff_width) : ta[WB-1:0];
        rb_r[k]  <= gb ? WB'(tb - eff_width) : tb[WB-1:0];
      end
    end
  end

  // Column and row differences, then their ordering.
  assign dx_ext = MW'(dx_r);
  assign dy_ext = MW'(dy_r);

  // Distance: 14*lo + 10*(hi - lo) folds to 10*hi + 4*lo, then saturates.
  assign dist_raw = DW'(STRAIGHT_K * DW'(hi_r)) + DW'(EXTRA_K * DW'(lo_r));
  assign dist_cmp = CW'(dist_raw);
  assign dist_sat = (dist_cmp > CW'(ogd_pkg::DIST_MAX)) ? ogd_pkg::DIST_MAX :
                    ogd_pkg::DIST_W'(dist_raw);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_v_r       <= 1'b0;
      y_v_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      x_v_r       <= v_r[IB-1];
      y_v_r       <= x_v_r;
      out_valid_r <= y_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dx_r       <= (ra_r[IB-1] > rb_r[IB-1]) ? ra_r[IB-1] - rb_r[IB-1]
                                              : rb_r[IB-1] - ra_r[IB-1];
      dy_r       <= (dqa_r[IB-1] > dqb_r[IB-1]) ? dqa_r[IB-1] - dqb_r[IB-1]
                                                : dqb_r[IB-1] - dqa_r[IB-1];
      lo_r       <= (dx_ext < dy_ext) ? dx_ext : dy_ext;
      hi_r       <= (dx_ext < dy_ext) ? dy_ext : dx_ext;
      out_dist_r <= dist_sat;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_distance_tenths = out_dist_r;

`ifndef ASSERT_OFF
  // A finished division leaves both remainders below the row width.
  a_rem_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[IB-1] |-> (({1'b0, ra_r[IB-1]} < eff_width) && ({1'b0, rb_r[IB-1]} < eff_width)))
    else $error("divider remainder not below row width");

  // Column difference can never reach the row width.
  a_dx_below_width: assert property (@(posedge clk) disable iff (!rst_n)
    x_v_r |-> ({1'b0, dx_r} < eff_width))
    else $error("column difference not below row width");
`endif

endmodule

FILE: rtl/octile_grid_distance_top.sv
// ----------------------------------------------------------------------------
// octile_grid_distance_top: octile distance between two grid cells
// Splits two row-major cell indices into row and column by the configured
// row width and returns their octile distance in tenths of a step.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_*: one item is a pair of linear cell indices, taken at a
//   clock edge where in_valid is high and in_stall is low.
//   Result channel out_*: one distance per item, in item order, taken at an
//   edge where out_valid is high and out_stall is low.
//   cfg_we/cfg_wdata write the row width; write it only while the block is
//   idle. Zero counts as one and values above 2**WIDTH_BITS are clamped.
// Timing:
//   A new item can be accepted every cycle while out_stall is low. An item
//   passes the input stage, the queue and the divider pipeline, which
//   retires one quotient bit per stage for both indices in parallel, then
//   the difference, ordering and output registers.
// Reset (rst_n low, synchronous): the pipeline and queue empty, no result is
//   shown and the row width returns to one.
// Back-pressure: while out_stall holds a result, the divider pipeline
//   freezes; the two-entry queue and the input stage then fill and in_stall
//   rises. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module octile_grid_distance_top #(
  parameter int unsigned INDEX_BITS = 24,
  parameter int unsigned WIDTH_BITS = 12
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ogd_pkg::CFG_W-1:0]          cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ogd_pkg::INDEX_FIELD_W-1:0]  in_first_index,
  input  logic [ogd_pkg::INDEX_FIELD_W-1:0]  in_second_index,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ogd_pkg::DIST_W-1:0]         out_distance_tenths
);

  localparam int unsigned QW = 2 * INDEX_BITS;

  logic                push;
  logic                q_full;
  logic [QW-1:0]       push_data;
  logic                q_pop;
  logic                q_not_empty;
  logic [QW-1:0]       pop_data;
  logic [WIDTH_BITS:0] eff_width;

  // Front: input capture and row width register.
  ogd_front #(
    .INDEX_BITS (INDEX_BITS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_first_index  (in_first_index),
    .in_second_index (in_second_index),
    .push_valid      (push),
    .push_full       (q_full),
    .push_data       (push_data),
    .eff_width       (eff_width)
  );

  // Queue between front and back.
  ogd_queue #(
    .DATA_W (QW),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_data),
    .not_empty (q_not_empty)
  );

  // Back: divider pipeline and distance output.
  ogd_back #(
    .INDEX_BITS (INDEX_BITS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_valid             (q_not_empty),
    .q_data              (pop_data),
    .q_pop               (q_pop),
    .eff_width           (eff_width),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distance_tenths (out_distance_tenths)
  );

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the octile grid distance block
// A table of directed index pairs is sent first, under several row widths.
// Random phases follow, each under a freshly written row width. Every
// distance that comes out is compared, in order, with the bench's own
// calculation. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned INDEX_BITS = 24;
  localparam int unsigned WIDTH_BITS = 12;

  // Field widths and step costs shared with the block.
  localparam int unsigned CFG_W           = ogd_pkg::CFG_W;
  localparam int unsigned INDEX_FIELD_W   = ogd_pkg::INDEX_FIELD_W;
  localparam int unsigned DIST_W          = ogd_pkg::DIST_W;
  localparam int unsigned DIAG_TENTHS     = ogd_pkg::DIAG_TENTHS;
  localparam int unsigned STRAIGHT_TENTHS = ogd_pkg::STRAIGHT_TENTHS;
  localparam logic [DIST_W-1:0] DIST_MAX  = ogd_pkg::DIST_MAX;

  localparam longint unsigned INDEX_MASK  = (64'd1 << INDEX_BITS) - 64'd1;
  localparam longint unsigned WIDTH_LIMIT = 64'd1 << WIDTH_BITS;

  localparam int unsigned RANDOM_ITEMS    = 800;
  localparam int unsigned MAX_IDLE        = 17;
  localparam int unsigned END_HOLDOFF     = 40;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  // One row of the directed table. The row width is written before the row
  // when wr_width is set. A typed distance is used when dist_known is set.
  typedef struct packed {
    bit                       wr_width;
    logic [CFG_W-1:0]         width;
    logic [INDEX_FIELD_W-1:0] idx_a;
    logic [INDEX_FIELD_W-1:0] idx_b;
    bit                       dist_known;
    logic [DIST_W-1:0]        exp_tenths;
  } pair_row_t;

  localparam int unsigned DIRECTED_ROWS = 23;

  localparam pair_row_t DIRECTED [DIRECTED_ROWS] = '{
    // Width one after reset: the distance is ten times the index gap.
    '{1'b0, 13'd0,    24'h000000, 24'h000000, 1'b1, 28'd0},
    '{1'b0, 13'd0,    24'h000000, 24'hFFFFFF, 1'b1, 28'd167772150},
    '{1'b0, 13'd0,    24'hFFFFFF, 24'h000000, 1'b1, 28'd167772150},
    '{1'b0, 13'd0,    24'hFFFFFF, 24'hFFFFFF, 1'b1, 28'd0},
    '{1'b0, 13'd0,    24'h123456, 24'h123450, 1'b1, 28'd60},
    // A zero width behaves as one.
    '{1'b1, 13'd0,    24'h000005, 24'h000002, 1'b1, 28'd30},
    '{1'b0, 13'd0,    24'hFFFFFF, 24'h000001, 1'b1, 28'd167772140},
    // Widest legal grid: opposite corners, one row, one column.
    '{1'b1, 13'd4096, 24'h000000, 24'hFFFFFF, 1'b1, 28'd57330},
    '{1'b0, 13'd0,    24'h000000, 24'h000FFF, 1'b1, 28'd40950},
    '{1'b0, 13'd0,    24'h000000, 24'h001000, 1'b1, 28'd10},
    '{1'b0, 13'd0,    24'h000000, 24'h001001, 1'b1, 28'd14},
    '{1'b0, 13'd0,    24'hFFF000, 24'h000FFF, 1'b1, 28'd57330},
    '{1'b0, 13'd0,    24'h800800, 24'h7FF7FF, 1'b0, 28'd0},
    // Oversized widths are clamped to the widest grid.
    '{1'b1, 13'h1FFF, 24'h000000, 24'hFFFFFF, 1'b1, 28'd57330},
    '{1'b0, 13'd0,    24'hFFFFFF, 24'h000000, 1'b1, 28'd57330},
    '{1'b1, 13'd4097, 24'h000001, 24'hFFFFFE, 1'b0, 28'd0},
    '{1'b1, 13'd4095, 24'h000000, 24'hFFFFFF, 1'b0, 28'd0},
    '{1'b0, 13'd0,    24'hA5A5A5, 24'h5A5A5A, 1'b0, 28'd0},
    // Narrow grids.
    '{1'b1, 13'd2,    24'h000000, 24'h000003, 1'b1, 28'd14},
    '{1'b0, 13'd0,    24'h000003, 24'h000000, 1'b1, 28'd14},
    '{1'b1, 13'd3,    24'h000007, 24'h000014, 1'b0, 28'd0},
    '{1'b1, 13'd1,    24'hABCDEF, 24'hABCDEF, 1'b1, 28'd0},
    '{1'b0, 13'd0,    24'hABCDEF, 24'hABCDE0, 1'b1, 28'd150}
  };

  logic                     clk;
  logic                     rst_n;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_stall;
  logic [INDEX_FIELD_W-1:0] in_first_index;
  logic [INDEX_FIELD_W-1:0] in_second_index;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DIST_W-1:0]        out_distance_tenths;

  // Expected distances in item order, and the bench's copy of the register.
  logic [DIST_W-1:0] pending_dist [$];
  logic [CFG_W-1:0]  row_width_q = 13'd1;

  int unsigned pairs_sent     = 0;
  int unsigned dists_checked  = 0;
  int unsigned err_count      = 0;
  int unsigned width_writes   = 0;
  int unsigned stall_left     = 0;
  int unsigned idle_cycles    = 0;
  bit          src_idle_en    = 1'b1;
  bit          sink_idle_en   = 1'b1;

  octile_grid_distance_top #(
    .INDEX_BITS (INDEX_BITS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_first_index      (in_first_index),
    .in_second_index     (in_second_index),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_distance_tenths (out_distance_tenths)
  );

  // Free-running clock, 20 ns period.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Octile distance in tenths between two cells, for a given register value.
  function automatic logic [DIST_W-1:0] octile_tenths(input logic [CFG_W-1:0] width_reg,
                                                      input logic [INDEX_FIELD_W-1:0] idx_a,
                                                      input logic [INDEX_FIELD_W-1:0] idx_b);
    longint unsigned w, a, b, col_a, col_b, row_a, row_b, dx, dy, lo, hi, d;
    w = 64'(width_reg);
    if (w == 0) w = 1;
    if (w > WIDTH_LIMIT) w = WIDTH_LIMIT;
    a = 64'(idx_a) & INDEX_MASK;
    b = 64'(idx_b) & INDEX_MASK;
    col_a = a % w;
    col_b = b % w;
    row_a = a / w;
    row_b = b / w;
    dx = (col_a > col_b) ? col_a - col_b : col_b - col_a;
    dy = (row_a > row_b) ? row_a - row_b : row_b - row_a;
    lo = (dx < dy) ? dx : dy;
    hi = (dx < dy) ? dy : dx;
    d  = DIAG_TENTHS * lo + STRAIGHT_TENTHS * (hi - lo);
    if (d > DIST_MAX) d = DIST_MAX;
    return d[DIST_W-1:0];
  endfunction

  // Present one index pair after a random gap and wait until it is taken.
  task automatic send_pair(input logic [INDEX_FIELD_W-1:0] idx_a,
                           input logic [INDEX_FIELD_W-1:0] idx_b,
                           input bit dist_known, input logic [DIST_W-1:0] exp_tenths);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_index  <= idx_a;
    in_second_index <= idx_b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pending_dist = {pending_dist,
                    (dist_known ? exp_tenths : octile_tenths(row_width_q, idx_a, idx_b))};
    pairs_sent++;
  endtask

  // Stop sending and wait until every outstanding distance has been checked.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (dists_checked != pairs_sent) @(posedge clk);
  endtask

  // Write the row width once the block has gone idle.
  task automatic write_row_width(input logic [CFG_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we      <= 1'b0;
    row_width_q  = value;
    width_writes++;
  endtask

  // Stimulus: reset, the directed table, then random phases.
  initial begin : stimulus
    logic [CFG_W-1:0]         w;
    logic [INDEX_FIELD_W-1:0] a, b;
    int unsigned              phase_len;
    int unsigned              delta;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_valid        = 1'b0;
    in_first_index  = '0;
    in_second_index = '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      if (DIRECTED[i].wr_width) write_row_width(DIRECTED[i].width);
      send_pair(DIRECTED[i].idx_a, DIRECTED[i].idx_b, DIRECTED[i].dist_known,
                DIRECTED[i].exp_tenths);
    end

    // Each random phase drains the block, writes a new width and runs a burst.
    while (pairs_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
      case ($urandom_range(0, 7))
        0:       w = 13'd0;
        1:       w = 13'd1;
        2:       w = 13'd4096;
        3:       w = 13'h1FFF;
        4, 5:    w = CFG_W'($urandom_range(1, 16));
        default: w = CFG_W'($urandom_range(0, 8191));
      endcase
      write_row_width(w);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(20, 80);
      repeat (phase_len) begin
        case ($urandom_range(0, 3))
          0, 1: begin
            a = INDEX_FIELD_W'($urandom);
            b = INDEX_FIELD_W'($urandom);
          end
          2: begin
            // Nearby cells give short distances across row boundaries.
            a     = INDEX_FIELD_W'($urandom);
            delta = $urandom_range(0, 20000);
            b     = $urandom_range(0, 1) ? INDEX_FIELD_W'(a + delta)
                                         : INDEX_FIELD_W'(a - delta);
          end
          default: begin
            a = $urandom_range(0, 1) ? 24'h000000 : 24'hFFFFFF;
            b = $urandom_range(0, 1) ? INDEX_FIELD_W'($urandom) : ~a;
            if ($urandom_range(0, 1)) {a, b} = {b, a};
          end
        endcase
        send_pair(a, b, 1'b0, '0);
      end
    end

    drain_results();
    repeat (END_HOLDOFF) @(posedge clk);

    $display("Run covered %0d index pairs (%0d directed) under %0d row width writes,",
             pairs_sent, DIRECTED_ROWS, width_writes);
    $display("including zero, 4096 and the oversized 8191; %0d distances checked, %0d errors.",
             dists_checked, err_count);
    if (err_count == 0 && pending_dist.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Result side: check each accepted distance and draw the stall for the next.
  always @(posedge clk) begin : result_check
    logic [DIST_W-1:0] want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_dist.size() == 0) begin
          $display("%0t: distance %0d with no item outstanding", $time,
                   out_distance_tenths);
          err_count++;
        end else begin
          want = pending_dist.pop_front();
          if (want !== out_distance_tenths) begin
            $display("%0t: distance mismatch, expected %0d, actual %0d", $time,
                     want, out_distance_tenths);
            err_count++;
          end
          dists_checked++;
        end
        stall_left = sink_idle_en ? $urandom_range(0, MAX_IDLE) : 0;
      end else if (stall_left != 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  // Watchdog: end the run if nothing moves on either channel for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule
